// ===== sv/tfp_pkg.sv =====
// Shared types, character codes and reset values for the telemetry frame parser.
`default_nettype none

package tfp_pkg;

    // Default longest frame in bytes, start and end characters included.
    localparam int MAX_FRAME_DEF = 512;

    // Character codes seen on the byte stream.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // Magnitude cap of the accumulator and the largest positive result.
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Field index saturation and field count saturation.
    localparam logic [4:0] IDX_MAX   = 5'd31;
    localparam logic [5:0] COUNT_MAX = 6'd63;

    // Configuration register indexes and reset values.
    localparam logic CFG_EXPECTED_FIELDS = 1'b0;
    localparam logic CFG_WANTED_CHANNEL  = 1'b1;
    localparam logic [4:0] EXPECTED_FIELDS_RST = 5'd20;
    localparam logic [7:0] WANTED_CHANNEL_RST  = 8'd1;

    // Result kinds.
    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        MODE_HUNT     = 2'd0,
        MODE_FRAME    = 2'd1,
        MODE_AFTER_CR = 2'd2
    } tfp_mode_t;

    typedef enum logic [1:0] {
        PH_LEADING = 2'd0,
        PH_SIGNED  = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_DONE    = 2'd3
    } tfp_phase_t;

    // Number parser state of the field in progress.
    typedef struct packed {
        logic [31:0] acc;
        logic        neg;
        tfp_phase_t  phase;
    } tfp_field_t;

    // Configuration register values.
    typedef struct packed {
        logic [4:0] expected_fields;
        logic [7:0] wanted_channel;
    } tfp_cfg_t;

    // One result item.
    typedef struct packed {
        logic               kind;
        logic [4:0]         field_index;
        logic signed [31:0] field_value;
        logic               checksum_ok;
        logic               count_ok;
        logic               channel_ok;
        logic               last;
    } tfp_result_t;

endpackage

`default_nettype wire

// ===== sv/telemetry_frame_parser.sv =====
// Top level of the telemetry frame parser: input register, frame logic, result register.
//
//  channel  | direction | transfer on                     | contents
//  s_axis   | in        | s_axis_tvalid & s_axis_tready   | one received byte
//  m_axis   | out       | m_axis_tvalid & m_axis_tready   | field result or frame report
//  cfg      | in        | cfg_we                          | expected_fields, wanted_channel
//
// One byte per cycle is sustained while results are taken; a byte passes the input register,
// then the result register, before its result can be taken.
// A byte that causes no result passes even while the result register is stalled.
// Reset is asynchronous and returns the parser to hunting for the start character,
// with the configuration registers at their reset values.
`default_nettype none

module telemetry_frame_parser
    import tfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [4:0] field_index, [36:5] field_value,
                                             // [37] checksum_ok, [38] count_ok,
                                             // [39] channel_ok
    output logic             m_axis_tuser,   // [0] kind
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    tfp_result_t out_reg;
    tfp_cfg_t    cfg_reg;

    logic        advance;
    logic        res_valid;
    tfp_result_t res;

    tfp_frame_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // The held byte moves on when its result, if any, has a free slot.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready || !res_valid);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_fields <= EXPECTED_FIELDS_RST;
            cfg_reg.wanted_channel  <= WANTED_CHANNEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_EXPECTED_FIELDS: cfg_reg.expected_fields <= cfg_wdata[4:0];
                CFG_WANTED_CHANNEL:  cfg_reg.wanted_channel  <= cfg_wdata;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Result port.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.channel_ok, out_reg.count_ok, out_reg.checksum_ok,
                            out_reg.field_value, out_reg.field_index};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

endmodule

`default_nettype wire

// ===== sv/tfp_field_parse.sv =====
// Decimal field parser: one character step and the signed, saturated field value.
`default_nettype none

module tfp_field_parse
    import tfp_pkg::*;
(
    input  wire logic [7:0]   rx_byte,
    input  wire tfp_field_t   cur,
    output tfp_field_t        nxt,
    output logic signed [31:0] value
);

    logic        is_digit;
    logic        is_space;
    logic [35:0] mag_wide;
    logic [3:0]  digit;

    // Character classes.
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign digit    = rx_byte[3:0];

    // Times ten as two shifts and an add, plus the new digit.
    assign mag_wide = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1) + {32'b0, digit};

    // One character step of the field state.
    always_comb
    begin
        nxt = cur;
        if (cur.phase != PH_DONE)
        begin
            if (is_digit)
            begin
                nxt.acc   = (mag_wide > {4'b0, MAG_CAP}) ? MAG_CAP : mag_wide[31:0];
                nxt.phase = PH_DIGITS;
            end
            else if ((cur.phase == PH_LEADING) && is_space)
            begin
                nxt.phase = PH_LEADING;
            end
            else if ((cur.phase == PH_LEADING) && ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)))
            begin
                nxt.neg   = (rx_byte == CH_MINUS);
                nxt.phase = PH_SIGNED;
            end
            else
            begin
                nxt.phase = PH_DONE;
            end
        end
    end

    // Signed value of the field so far; the magnitude never exceeds 2^31.
    always_comb
    begin
        if (cur.neg)
        begin
            value = $signed(32'd0 - cur.acc);
        end
        else
        begin
            value = $signed(cur.acc[31] ? POS_MAX : cur.acc);
        end
    end

endmodule

`default_nettype wire

// ===== sv/tfp_frame_ctrl.sv =====
// Frame state machine: start hunt, checksum, field counting and frame report.
`default_nettype none

module tfp_frame_ctrl
    import tfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire tfp_cfg_t   cfg,
    output logic            res_valid,
    output tfp_result_t     res
);

    localparam int BC_W = $clog2(MAX_FRAME + 1);

    tfp_mode_t          mode_reg, mode_next;
    logic [7:0]         xor_reg, xor_next;
    logic [7:0]         xor_semi_reg, xor_semi_next;
    tfp_field_t         field_reg, field_next;
    logic [5:0]         count_reg, count_next;
    logic signed [31:0] first_reg, first_next;
    logic signed [31:0] last_val_reg, last_val_next;
    logic [BC_W-1:0]    bc_reg, bc_next;

    tfp_field_t         field_step;
    logic signed [31:0] field_value;
    logic [4:0]         idx_sat;
    logic [7:0]         xor_upd;

    localparam tfp_field_t FIELD_CLEAR = '{acc: 32'd0, neg: 1'b0, phase: PH_LEADING};

    tfp_field_parse u_parse (
        .rx_byte (rx_byte),
        .cur     (field_reg),
        .nxt     (field_step),
        .value   (field_value)
    );

    assign idx_sat = count_reg[5] ? IDX_MAX : count_reg[4:0];
    assign xor_upd = xor_reg ^ rx_byte;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_HUNT;
            xor_reg      <= '0;
            xor_semi_reg <= '0;
            field_reg    <= FIELD_CLEAR;
            count_reg    <= '0;
            first_reg    <= '0;
            last_val_reg <= '0;
            bc_reg       <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            xor_reg      <= xor_next;
            xor_semi_reg <= xor_semi_next;
            field_reg    <= field_next;
            count_reg    <= count_next;
            first_reg    <= first_next;
            last_val_reg <= last_val_next;
            bc_reg       <= bc_next;
        end
    end

    // Next state and the result caused by the current byte.
    always_comb
    begin
        mode_next     = mode_reg;
        xor_next      = xor_reg;
        xor_semi_next = xor_semi_reg;
        field_next    = field_reg;
        count_next    = count_reg;
        first_next    = first_reg;
        last_val_next = last_val_reg;
        bc_next       = bc_reg;
        res_valid     = 1'b0;
        res           = '0;

        unique case (mode_reg) inside
            MODE_HUNT:
            begin
                if (rx_byte == CH_DOLLAR)
                begin
                    mode_next     = MODE_FRAME;
                    xor_next      = rx_byte;
                    xor_semi_next = rx_byte;
                    bc_next       = BC_W'(1);
                    count_next    = '0;
                    first_next    = '0;
                    last_val_next = '0;
                    field_next    = FIELD_CLEAR;
                end
            end
            MODE_FRAME, MODE_AFTER_CR:
            begin
                if (bc_reg >= BC_W'(MAX_FRAME))
                begin
                    // Overlong frame: drop the byte and go back to hunting.
                    mode_next  = MODE_HUNT;
                    bc_next    = '0;
                    field_next = FIELD_CLEAR;
                end
                else if ((mode_reg == MODE_AFTER_CR) && (rx_byte == CH_LF))
                begin
                    // End of frame report.
                    res_valid       = 1'b1;
                    res.kind        = KIND_REPORT;
                    res.field_index = idx_sat;
                    res.checksum_ok = (last_val_reg == $signed({24'b0, xor_semi_reg}));
                    res.count_ok    = (count_reg == {1'b0, cfg.expected_fields});
                    res.channel_ok  = (count_reg != 6'd0)
                                   && (first_reg == $signed({24'b0, cfg.wanted_channel}));
                    res.last        = 1'b1;
                    mode_next       = MODE_HUNT;
                    bc_next         = '0;
                    field_next      = FIELD_CLEAR;
                end
                else
                begin
                    bc_next   = bc_reg + BC_W'(1);
                    mode_next = MODE_FRAME;
                    xor_next  = xor_upd;
                    if ((rx_byte == CH_SEMI) || (rx_byte == CH_CR))
                    begin
                        // A field ends here.
                        if (rx_byte == CH_SEMI)
                        begin
                            xor_semi_next = xor_upd;
                        end
                        else
                        begin
                            mode_next = MODE_AFTER_CR;
                        end
                        res_valid       = 1'b1;
                        res.kind        = KIND_FIELD;
                        res.field_index = idx_sat;
                        res.field_value = field_value;
                        if (count_reg == 6'd0)
                        begin
                            first_next = field_value;
                        end
                        last_val_next = field_value;
                        if (count_reg < COUNT_MAX)
                        begin
                            count_next = count_reg + 6'd1;
                        end
                        field_next = FIELD_CLEAR;
                    end
                    else
                    begin
                        field_next = field_step;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_HUNT;
            end
        endcase

        // Only an accepted byte moves the state.
        if (!step)
        begin
            mode_next     = mode_reg;
            xor_next      = xor_reg;
            xor_semi_next = xor_semi_reg;
            field_next    = field_reg;
            count_next    = count_reg;
            first_next    = first_reg;
            last_val_next = last_val_reg;
            bc_next       = bc_reg;
        end
    end

endmodule

`default_nettype wire
